@@ rtl/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg
// Types, constants and lead-byte helpers shared by the UTF-8 decoder modules.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;

    // Two bits per high nibble, nibble 0xF in the lowest pair.
    localparam logic [15:0] LEAD_NIBBLE_COUNTS = 16'h555B;
    // One payload mask per trailing count, count 0 in the lowest byte.
    localparam logic [31:0] LEAD_BIT_MASKS     = 32'h070F1F7F;
    localparam logic [5:0]  CONT_BITS          = 6'h3F;

    localparam logic [CP_W-1:0] LOW_SUR_FIRST  = 21'h00DC00;
    localparam logic [CP_W-1:0] LOW_SUR_LAST   = 21'h00DFFF;
    localparam logic [CP_W-1:0] HIGH_SUR_FIRST = 21'h00D800;
    localparam logic [CP_W-1:0] HIGH_SUR_LAST  = 21'h00DBFF;
    localparam logic [CP_W-1:0] SUPP_BASE      = 21'h010000;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_string;
    } byte_item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaces_previous;
    } cp_item_t;

    // Handoff from the input register to the decode stage.
    typedef struct packed {
        logic       valid;
        byte_item_t item;
    } stage_t;

    // Decoder state seen from outside the core.
    typedef struct packed {
        logic [1:0] bytes_owed;
        logic       have_previous;
    } status_t;

    // Trailing bytes owed by a lead byte, from its high nibble.
    function automatic logic [1:0] lead_owed(input logic [3:0] nib);
        logic [15:0] shifted;
        shifted = LEAD_NIBBLE_COUNTS >> {~nib, 1'b0};
        return nib[3] ? shifted[1:0] : 2'd0;
    endfunction

    // Payload bits kept from a lead byte for a given trailing count.
    function automatic logic [BYTE_W-1:0] lead_mask(input logic [1:0] owed);
        logic [31:0] shifted;
        shifted = LEAD_BIT_MASKS >> {owed, 3'b000};
        return shifted[BYTE_W-1:0];
    endfunction

endpackage

@@ rtl/utf8_decoder_surrogate_join.sv @@
// ----------------------------------------------------------------------------
// utf8_decoder_surrogate_join
// Lenient UTF-8 decoder, one byte per transfer, joining surrogate pairs.
// ----------------------------------------------------------------------------
// Path: a byte goes into the input register, is decoded from there, and a
// completed code point is registered in the result register for the port.
// Throughput: one byte per cycle unless a result waits, and then the input
// register holds one more byte; the decode stage updates state in one pass.
// Reset: rst_n clears the sequence state, the previous code point and both
// valid flags; payload registers are not reset.
module utf8_decoder_surrogate_join
    import u8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  byte_item_t byte_item,
    output logic       cp_valid,
    input  logic       cp_ready,
    output cp_item_t   cp_item
);

    stage_t  stage;
    logic    take;
    status_t status;

    u8d_input_stage u_input
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .take       (take),
        .stage      (stage)
    );

    u8d_decode_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage    (stage),
        .take     (take),
        .cp_valid (cp_valid),
        .cp_ready (cp_ready),
        .cp_item  (cp_item),
        .status   (status)
    );

    // A joined value always lies in the supplementary planes.
    a_join_range: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && cp_item.replaces_previous |-> cp_item.code_point >= SUPP_BASE)
        else $error("joined code point below the supplementary base");

    // End of string leaves the decoder empty.
    a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        take && stage.item.end_of_string |=>
            status.bytes_owed == 2'd0 && !status.have_previous)
        else $error("state not cleared after end of string");

    // The input side stalls only while the input register holds a byte and a result waits.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_ready |-> stage.valid && cp_valid && !cp_ready)
        else $error("input stalled without a pending byte and a blocked result");

    // A waiting result holds, unchanged, until its transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid && !cp_ready |=> cp_valid && $stable(cp_item))
        else $error("result changed while waiting for a transfer");

endmodule

@@ rtl/u8d_input_stage.sv @@
// ----------------------------------------------------------------------------
// u8d_input_stage
// Input register: holds one byte until the decode stage takes it.
// ----------------------------------------------------------------------------
module u8d_input_stage
    import u8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  byte_item_t byte_item,
    input  logic       take,
    output stage_t     stage
);

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;

    // The register frees up in the same cycle that the decode stage takes it.
    assign byte_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_ready)
        begin
            valid_next = byte_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            item_reg <= byte_item;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

@@ rtl/u8d_decode_core.sv @@
// ----------------------------------------------------------------------------
// u8d_decode_core
// Sequence state, surrogate join and the result register.
// ----------------------------------------------------------------------------
module u8d_decode_core
    import u8d_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  stage_t   stage,
    output logic     take,
    output logic     cp_valid,
    input  logic     cp_ready,
    output cp_item_t cp_item,
    output status_t  status
);

    logic [CP_W-1:0] partial_reg;
    logic [CP_W-1:0] partial_next;
    logic [1:0]      owed_reg;
    logic [1:0]      owed_next;
    logic            have_prev_reg;
    logic            have_prev_next;
    logic [CP_W-1:0] prev_reg;
    logic [CP_W-1:0] prev_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    cp_item_t        out_item_reg;

    logic [BYTE_W-1:0] b;
    logic [1:0]        lead_cnt;
    logic              done;
    logic              is_low;
    logic              is_high;
    logic              do_join;
    logic [CP_W-1:0]   joined;
    cp_item_t          result;

    // The result register is free, or is being emptied this cycle.
    assign take = stage.valid && (!out_valid_reg || cp_ready);
    assign b    = stage.item.in_byte;

    always_comb
    begin
        lead_cnt = lead_owed(b[7:4]);
        if (owed_reg != 2'd0)
        begin
            // Any byte is a continuation here, whatever its top bits.
            partial_next = {partial_reg[CP_W-7:0], b[5:0] & CONT_BITS};
            owed_next    = owed_reg - 2'd1;
            done         = (owed_reg == 2'd1);
        end
        else
        begin
            partial_next = {{(CP_W-BYTE_W){1'b0}}, b & lead_mask(lead_cnt)};
            owed_next    = lead_cnt;
            done         = (lead_cnt == 2'd0);
        end

        is_low  = (partial_next >= LOW_SUR_FIRST) && (partial_next <= LOW_SUR_LAST);
        is_high = (prev_reg >= HIGH_SUR_FIRST) && (prev_reg <= HIGH_SUR_LAST);
        do_join = have_prev_reg && is_low && is_high;
        // Both halves are ten bits above their range bases.
        joined  = {1'b0, prev_reg[9:0], partial_next[9:0]} + SUPP_BASE;

        result.code_point        = do_join ? joined : partial_next;
        result.replaces_previous = do_join;

        have_prev_next = have_prev_reg;
        prev_next      = prev_reg;
        if (done)
        begin
            have_prev_next = 1'b1;
            prev_next      = result.code_point;
        end

        if (stage.item.end_of_string)
        begin
            partial_next   = '0;
            owed_next      = 2'd0;
            have_prev_next = 1'b0;
            prev_next      = '0;
        end

        out_valid_next = out_valid_reg && !cp_ready;
        if (take)
        begin
            out_valid_next = done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            owed_reg      <= 2'd0;
            have_prev_reg <= 1'b0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                partial_reg   <= partial_next;
                owed_reg      <= owed_next;
                have_prev_reg <= have_prev_next;
                prev_reg      <= prev_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && done)
        begin
            out_item_reg <= result;
        end
    end

    assign cp_valid             = out_valid_reg;
    assign cp_item              = out_item_reg;
    assign status.bytes_owed    = owed_reg;
    assign status.have_previous = have_prev_reg;

endmodule
